[rtl/fdt_pkg.sv]
package fdt_pkg;

  localparam int PC_W = 5;

  // Exponent window for fixed-point printing, and the single-precision bias.
  localparam logic [7:0] EXP_LO = 8'd110;
  localparam logic [7:0] EXP_HI = 8'd147;
  localparam logic [7:0] EXP_BIAS = 8'd127;
  localparam logic [7:0] EXP_MAX = 8'hFF;
  localparam logic [31:0] ADDEND_RESET = 32'h3851_B717;

  // Register word indexes on the configuration port.
  localparam logic REG_ROUND_ADDEND = 1'b0;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // Canned texts.
  localparam logic [1:0] TXT_NAN  = 2'd0;
  localparam logic [1:0] TXT_ZERO = 2'd1;
  localparam logic [1:0] TXT_PINF = 2'd2;
  localparam logic [1:0] TXT_NINF = 2'd3;

  typedef enum logic [4:0] {
    OP_WAIT, OP_CLASS, OP_NOP, OP_ALIGN, OP_ADD, OP_NORM1, OP_NORML, OP_ROUND,
    OP_UNPACK, OP_DABBLE, OP_FRACG, OP_TRIM, OP_SIGN, OP_INT, OP_POINT,
    OP_FRACE, OP_SCI, OP_TEXT
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER, C_ALWAYS, C_NOIN, C_TEXT, C_RANGE, C_ADDINF, C_ZZERO, C_NOTNORM,
    C_SUMBAD, C_MORE
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic             fin;     // on a false condition return to step zero
    logic [PC_W-1:0]  target;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      5'd0:    w = '{OP_WAIT,   C_NOIN,    1'b0, 5'd0};
      5'd1:    w = '{OP_CLASS,  C_TEXT,    1'b0, 5'd18};
      5'd2:    w = '{OP_NOP,    C_RANGE,   1'b0, 5'd17};
      5'd3:    w = '{OP_ALIGN,  C_ADDINF,  1'b0, 5'd8};
      5'd4:    w = '{OP_ADD,    C_ZZERO,   1'b0, 5'd8};
      5'd5:    w = '{OP_NORM1,  C_NEVER,   1'b0, 5'd0};
      5'd6:    w = '{OP_NORML,  C_NOTNORM, 1'b0, 5'd6};
      5'd7:    w = '{OP_ROUND,  C_NEVER,   1'b0, 5'd0};
      5'd8:    w = '{OP_UNPACK, C_SUMBAD,  1'b0, 5'd16};
      5'd9:    w = '{OP_DABBLE, C_MORE,    1'b0, 5'd9};
      5'd10:   w = '{OP_FRACG,  C_MORE,    1'b0, 5'd10};
      5'd11:   w = '{OP_TRIM,   C_NEVER,   1'b0, 5'd0};
      5'd12:   w = '{OP_SIGN,   C_NEVER,   1'b0, 5'd0};
      5'd13:   w = '{OP_INT,    C_MORE,    1'b0, 5'd13};
      5'd14:   w = '{OP_POINT,  C_NEVER,   1'b0, 5'd0};
      5'd15:   w = '{OP_FRACE,  C_MORE,    1'b1, 5'd15};
      5'd16:   w = '{OP_SIGN,   C_NEVER,   1'b0, 5'd0};
      5'd17:   w = '{OP_SCI,    C_NEVER,   1'b1, 5'd0};
      5'd18:   w = '{OP_TEXT,   C_MORE,    1'b1, 5'd18};
      default: w = '{OP_WAIT,   C_NEVER,   1'b1, 5'd0};
    endcase
    return w;
  endfunction

  function automatic logic [7:0] text_char(input logic [1:0] sel, input logic [1:0] idx);
    logic [7:0] c;
    c = 8'h00;
    case (sel)
      TXT_NAN: begin
        case (idx)
          2'd0:    c = 8'h4E;
          2'd1:    c = 8'h61;
          default: c = 8'h4E;
        endcase
      end
      TXT_ZERO: begin
        case (idx)
          2'd1:    c = CH_POINT;
          default: c = CH_ZERO;
        endcase
      end
      default: begin
        case (idx)
          2'd0:    c = (sel == TXT_NINF) ? CH_MINUS : 8'h2B;
          2'd1:    c = 8'h49;
          2'd2:    c = 8'h6E;
          default: c = 8'h66;
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

[rtl/float_to_fixed_decimal_text_top.sv]
// Converts one IEEE single-precision word per input beat into its fixed-point
// decimal text, one ASCII character per output beat, with tlast on the final
// character. NaN prints "NaN", either zero prints "0.0", infinities print
// "+Inf" or "-Inf". Other values print an optional '-', then the magnitude
// plus the round_addend register (a round-to-nearest-even single add), as
// integer digits, '.', and FRACTION_DIGITS fraction digits with trailing
// zeros trimmed down to one. A biased exponent outside 110..146, or a sum
// that is not finite or has an unbiased exponent above 23, gives a beat with
// tuser set and character 0 (after any '-' already sent). One value is in
// work at a time. The integer part goes through the 24-step binary-to-BCD
// loop, and the fraction digits come from the shared one-digit-per-cycle
// fraction multiplier. The adder's normalize loop shifts out one leading
// zero per step. A sum of exactly zero skips the normalize and round steps.
// The output register lets a character wait for tready while the sequencer
// goes on with steps that emit nothing; an emitting step stalls in place
// until the register is free.
module float_to_fixed_decimal_text_top #(
  parameter int FRACTION_DIGITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream: tdata = float_bits[31:0].
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,
  // Output stream: tdata = char_out[7:0], tlast = last_char,
  // tuser = needs_scientific.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,
  output logic        m_tlast,
  output logic        m_tuser,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fdt_pkg::*;

  localparam int FI_W = (FRACTION_DIGITS > 1) ? $clog2(FRACTION_DIGITS) : 1;
  localparam int NK_W = $clog2(FRACTION_DIGITS + 1);

  // Sequencer state.
  logic [PC_W-1:0] pc;
  logic [4:0]      cnt;
  ctrl_t           cw;

  // Datapath registers.
  logic [31:0] ra;
  logic [30:0] f_mag;
  logic        neg;
  logic [55:0] x, y, z;
  logic        sa, sub;
  logic [9:0]  e;
  logic [31:0] s;
  logic [23:0] ip;
  logic [31:0] bcd;
  logic [23:0] fr;
  logic [3:0]  fd [FRACTION_DIGITS];
  logic [NK_W-1:0] nfk;
  logic [1:0]  tsel;
  logic [2:0]  tlen;

  // Configuration port: always ready, one word register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ROUND_ADDEND) ? ra : 32'd0;

  assign cw = ucode(pc);
  assign s_tready = (cw.op == OP_WAIT);

  // Classification of the held input.
  logic [7:0]  ef;
  logic        is_nan, is_zero, is_inf, is_text, out_rng;
  always_comb begin
    ef      = f_mag[30:23];
    is_nan  = (ef == EXP_MAX) && (f_mag[22:0] != 23'd0);
    is_zero = (ef == 8'd0) && (f_mag[22:0] == 23'd0);
    is_inf  = (ef == EXP_MAX) && (f_mag[22:0] == 23'd0);
    is_text = is_nan || is_zero || is_inf;
    out_rng = (ef < EXP_LO) || (ef >= EXP_HI);
  end

  // Operand swap and alignment with sticky collection.
  logic [7:0]  eb, el, es, dsh;
  logic [23:0] mb, ml, ms;
  logic        swap, sl, ss, lost;
  logic [55:0] yfull, yshift, y_al;
  always_comb begin
    eb   = (ra[30:23] == 8'd0) ? 8'd1 : ra[30:23];
    mb   = {(ra[30:23] != 8'd0), ra[22:0]};
    swap = (f_mag[30:23] < eb) ||
           ((f_mag[30:23] == eb) && ({1'b1, f_mag[22:0]} < mb));
    el   = swap ? eb : f_mag[30:23];
    es   = swap ? f_mag[30:23] : eb;
    ml   = swap ? mb : {1'b1, f_mag[22:0]};
    ms   = swap ? {1'b1, f_mag[22:0]} : mb;
    sl   = swap ? ra[31] : 1'b0;
    ss   = swap ? 1'b0 : ra[31];
    dsh  = el - es;
    yfull  = {2'b00, ms, 30'd0};
    yshift = yfull >> dsh;
    lost   = (yfull & ((56'd1 << dsh) - 56'd1)) != 56'd0;
    if (dsh >= 8'd62) begin
      y_al = {55'd0, (ms != 24'd0)};
    end else begin
      y_al = yshift | {55'd0, lost};
    end
  end

  logic [55:0] zsum;
  assign zsum = sub ? (x - y) : (x + y);

  logic notnorm;
  assign notnorm = !z[53] && (e > 10'd1);

  // Rounding and packing.
  logic [29:0] rem;
  logic [24:0] q0, q1, q2;
  logic        rinc;
  logic [9:0]  e2, field;
  logic [31:0] s_rnd;
  always_comb begin
    rem  = z[29:0];
    q0   = z[54:30];
    rinc = (rem > 30'h2000_0000) || ((rem == 30'h2000_0000) && q0[0]);
    q1   = q0 + {24'd0, rinc};
    if (q1[24]) begin
      q2 = q1 >> 1;
      e2 = e + 10'd1;
    end else begin
      q2 = q1;
      e2 = e;
    end
    field = q2[23] ? e2 : 10'd0;
    if (field >= 10'd255) begin
      s_rnd = {sa, EXP_MAX, 23'd0};
    end else begin
      s_rnd = {sa, field[7:0], q2[22:0]};
    end
  end

  // Split of the sum into integer and fraction parts.
  logic [7:0]  sf, rsh;
  logic        sumbad;
  logic [23:0] mm, ip_u, frac_u;
  logic [47:0] mw;
  always_comb begin
    sf     = s[30:23];
    sumbad = (sf == EXP_MAX) || (sf > 8'd150);
    mm     = {1'b1, s[22:0]};
    mw     = 48'd0;
    rsh    = 8'd0;
    ip_u   = 24'd0;
    frac_u = 24'd0;
    if (sf >= EXP_BIAS) begin
      rsh    = 8'd150 - sf;
      ip_u   = mm >> rsh;
      mw     = {24'd0, mm} << (sf - 8'd126);
      frac_u = mw[23:0];
    end else begin
      rsh    = 8'd126 - sf;
      frac_u = (rsh >= 8'd24) ? 24'd0 : (mm >> rsh);
    end
  end

  // One double-dabble step.
  logic [31:0] bcd_adj;
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? (bcd[4*i +: 4] + 4'd3)
                                                   : bcd[4*i +: 4];
    end
  end

  // One fraction digit: fr times ten.
  logic [27:0] fr10;
  logic [FI_W-1:0] gidx, eidx;
  logic [NK_W-1:0] etmp;
  assign fr10 = {1'b0, fr, 3'd0} + {3'd0, fr, 1'b0};
  assign gidx = FI_W'(FRACTION_DIGITS - 1) - cnt[FI_W-1:0];
  assign etmp = nfk - NK_W'(1) - cnt[NK_W-1:0];
  assign eidx = etmp[FI_W-1:0];

  // Digit counts after trimming.
  logic [3:0]      nint_c;
  logic [NK_W-1:0] nfk_c;
  always_comb begin
    nint_c = 4'd1;
    for (int i = 0; i < 8; i++) begin
      if (bcd[4*i +: 4] != 4'd0) nint_c = 4'(i + 1);
    end
    nfk_c = NK_W'(1);
    for (int i = 0; i < FRACTION_DIGITS; i++) begin
      if (fd[i] != 4'd0) nfk_c = NK_W'(i + 1);
    end
  end

  // Character selection for the emitting steps.
  logic       emit_req, stall, emit_go;
  logic [7:0] ch;
  logic       ch_last, ch_sci;
  logic [2:0] ttmp;
  always_comb begin
    emit_req = 1'b0;
    ch       = 8'd0;
    ch_last  = 1'b0;
    ch_sci   = 1'b0;
    ttmp     = tlen - 3'd1 - cnt[2:0];
    case (cw.op)
      OP_SIGN: begin
        emit_req = neg;
        ch       = CH_MINUS;
      end
      OP_INT: begin
        emit_req = 1'b1;
        ch       = CH_ZERO + {4'd0, bcd[4*cnt[2:0] +: 4]};
      end
      OP_POINT: begin
        emit_req = 1'b1;
        ch       = CH_POINT;
      end
      OP_FRACE: begin
        emit_req = 1'b1;
        ch       = CH_ZERO + {4'd0, fd[eidx]};
        ch_last  = (cnt == 5'd0);
      end
      OP_SCI: begin
        emit_req = 1'b1;
        ch_last  = 1'b1;
        ch_sci   = 1'b1;
      end
      OP_TEXT: begin
        emit_req = 1'b1;
        ch       = text_char(tsel, ttmp[1:0]);
        ch_last  = (cnt == 5'd0);
      end
      default: emit_req = 1'b0;
    endcase
    stall   = emit_req && m_tvalid && !m_tready;
    emit_go = emit_req && !stall;
  end

  // Branch condition and next step.
  logic            cond_true;
  logic [PC_W-1:0] pc_next;
  always_comb begin
    case (cw.cond)
      C_ALWAYS:  cond_true = 1'b1;
      C_NOIN:    cond_true = !s_tvalid;
      C_TEXT:    cond_true = is_text;
      C_RANGE:   cond_true = out_rng;
      C_ADDINF:  cond_true = (ra[30:23] == EXP_MAX);
      C_ZZERO:   cond_true = (zsum == 56'd0);
      C_NOTNORM: cond_true = notnorm;
      C_SUMBAD:  cond_true = sumbad;
      C_MORE:    cond_true = (cnt != 5'd0);
      default:   cond_true = 1'b0;
    endcase
    if (stall) begin
      pc_next = pc;
    end else if (cond_true) begin
      pc_next = cw.target;
    end else if (cw.fin) begin
      pc_next = '0;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= '0;
      ra       <= ADDEND_RESET;
      m_tvalid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (psel && penable && pwrite && pready && (paddr[2] == REG_ROUND_ADDEND)) begin
        ra <= pwdata;
      end
      if (emit_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers, driven by the current control word.
  always_ff @(posedge clk) begin
    if (emit_go) begin
      m_tdata <= ch;
      m_tlast <= ch_last;
      m_tuser <= ch_sci;
    end
    if (!stall) begin
      case (cw.op)
        OP_WAIT: begin
          if (s_tvalid) begin
            f_mag <= s_tdata[30:0];
            neg   <= s_tdata[31];
          end
        end
        OP_CLASS: begin
          if (is_nan) begin
            tsel <= TXT_NAN;
            tlen <= 3'd3;
            cnt  <= 5'd2;
          end else if (is_zero) begin
            tsel <= TXT_ZERO;
            tlen <= 3'd3;
            cnt  <= 5'd2;
          end else begin
            tsel <= neg ? TXT_NINF : TXT_PINF;
            tlen <= 3'd4;
            cnt  <= 5'd3;
          end
        end
        OP_ALIGN: begin
          x   <= {2'b00, ml, 30'd0};
          y   <= y_al;
          sa  <= sl;
          sub <= (sl != ss);
          e   <= {2'b00, el};
          s   <= {1'b0, EXP_MAX, ra[22:0]};
        end
        OP_ADD: begin
          z <= zsum;
          s <= 32'd0;
        end
        OP_NORM1: begin
          if (z[54]) begin
            z <= {1'b0, z[55:1]} | {55'd0, z[0]};
            e <= e + 10'd1;
          end
        end
        OP_NORML: begin
          if (notnorm) begin
            z <= {z[54:0], 1'b0};
            e <= e - 10'd1;
          end
        end
        OP_ROUND:  s <= s_rnd;
        OP_UNPACK: begin
          ip  <= ip_u;
          fr  <= frac_u;
          bcd <= 32'd0;
          cnt <= 5'd23;
        end
        OP_DABBLE: begin
          bcd <= {bcd_adj[30:0], ip[23]};
          ip  <= {ip[22:0], 1'b0};
          cnt <= (cnt == 5'd0) ? 5'(FRACTION_DIGITS - 1) : (cnt - 5'd1);
        end
        OP_FRACG: begin
          fd[gidx] <= fr10[27:24];
          fr       <= fr10[23:0];
          if (cnt != 5'd0) cnt <= cnt - 5'd1;
        end
        OP_TRIM: begin
          nfk  <= nfk_c;
          cnt  <= 5'(nint_c) - 5'd1;
        end
        OP_INT:   cnt <= (cnt == 5'd0) ? (5'(nfk) - 5'd1) : (cnt - 5'd1);
        OP_FRACE: if (cnt != 5'd0) cnt <= cnt - 5'd1;
        OP_TEXT:  if (cnt != 5'd0) cnt <= cnt - 5'd1;
        default: begin
        end
      endcase
    end
  end

endmodule
